// ===== src/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// Button event detector package
// Shared types, register indexes, reset defaults and ramp constants.
// ----------------------------------------------------------------------------
package bed_pkg;

  localparam int unsigned BTN_COUNT = 4;
  localparam int unsigned BTN_IDX_W = 2;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_REPEAT_MASK = 2'd0,
    REG_POLL        = 2'd1,
    REG_DELAY       = 2'd2,
    REG_LONG        = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    KIND_PRESS  = 2'd0,
    KIND_CLICK  = 2'd1,
    KIND_REPEAT = 2'd2,
    KIND_LONG   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POLL,
    ST_EVAL,
    ST_RAMP,
    ST_DIV,
    ST_MOD,
    ST_DRAIN
  } state_e;

  // Status of the remainder unit toward the sequencer.
  typedef struct packed {
    logic done;
    logic zero;
  } mod_st_t;

  localparam logic [3:0]  RST_REPEAT_MASK = 4'd0;
  localparam logic [9:0]  RST_POLL        = 10'd20;
  localparam logic [13:0] RST_DELAY       = 14'd300;
  localparam logic [15:0] RST_LONG        = 16'd1800;

  localparam logic [10:0] RAMP_SPAN    = 11'd2000;
  localparam int unsigned RAMP_STEP    = 200;
  localparam int unsigned RAMP_DIV_MAX = 10;

  // Number of whole ramp steps in d, i.e. d / 200 for d up to 2000.
  function automatic logic [3:0] ramp_div(input logic [10:0] d);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int k = 1; k <= RAMP_DIV_MAX; k++) begin
      if (d >= 11'(k * RAMP_STEP)) begin
        cnt = cnt + 4'd1;
      end
    end
    return cnt;
  endfunction

endpackage

// ===== src/bed_mod_unit.sv =====
// ----------------------------------------------------------------------------
// Button event detector remainder unit
// Iterative 32-bit by 4-bit remainder, four dividend bits per cycle.
// ----------------------------------------------------------------------------
module bed_mod_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      dividend_i,
  input  logic [3:0]       divisor_i,
  output bed_pkg::mod_st_t status_o
);
  import bed_pkg::*;

  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned BITS_PER_CYC = 4;
  localparam int unsigned NUM_STEPS = DIVIDEND_W / BITS_PER_CYC;
  localparam int unsigned STEP_W = $clog2(NUM_STEPS);

  logic                  busy_q, busy_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [DIVIDEND_W-1:0] shift_q, shift_d;
  logic [3:0]            rem_q, rem_d;
  logic [3:0]            divisor_q;
  logic [4:0]            partial;
  logic [3:0]            rem_nx;

  // Restoring remainder: the partial remainder stays below the divisor.
  always_comb begin
    rem_nx = rem_q;
    partial = 5'd0;
    for (int b = 0; b < BITS_PER_CYC; b++) begin
      partial = {rem_nx, shift_q[DIVIDEND_W-1-b]};
      if (partial >= {1'b0, divisor_q}) begin
        partial = partial - {1'b0, divisor_q};
      end
      rem_nx = partial[3:0];
    end
  end

  always_comb begin
    busy_d  = busy_q;
    step_d  = step_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      step_d  = '0;
      shift_d = dividend_i;
      rem_d   = 4'd0;
    end else if (busy_q) begin
      shift_d = shift_q << BITS_PER_CYC;
      rem_d   = rem_nx;
      step_d  = step_q + 1'b1;
      if (step_q == STEP_W'(NUM_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  assign status_o.done = busy_q && (step_q == STEP_W'(NUM_STEPS - 1));
  assign status_o.zero = (rem_nx == 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

endmodule

// ===== src/button_event_detector.sv =====
// ----------------------------------------------------------------------------
// Button event detector
// Press, click, long click and accelerating auto-repeat from timed samples.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tdata: now_ms[31:0], pin_levels[35:32], press_claims[39:36]
//  m_axis    out        tdata: button_index; tuser: event_kind; tlast: last event
//  cfg       in         write enable, register index, write data
//
// A sample beat is taken only in idle. The poll check comes first, then each button
// is evaluated in turn; a held repeat button also passes the ramp check and, once past
// the delay, the divide step, plus the remainder unit when the ramp divisor is nonzero
// (four dividend bits per cycle).
// Events of a sample are then sent, one beat per cycle while the sink is ready.
// A stalled sink holds the current event; no new sample is taken until all drain.
// Reset clears the control state and pending events; configuration returns to its default values.
module button_event_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // now_ms, pin_levels, press_claims
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // button_index, zero fill
  output logic [1:0]  m_axis_tuser_o,   // event_kind
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import bed_pkg::*;

  localparam int unsigned NB = BTN_COUNT;

  state_e               state_q, state_d;
  logic [BTN_IDX_W-1:0] idx_q, idx_d;

  logic [3:0]  rep_mask_q, rep_mask_d;
  logic [9:0]  poll_q, poll_d;
  logic [13:0] delay_q, delay_d;
  logic [15:0] long_q, long_d;

  logic [NB-1:0] pressed_q, pressed_d;
  logic [31:0]   last_poll_q, last_poll_d;
  logic [31:0]   hold_q, hold_d;
  logic [31:0]   ctr_q, ctr_d;
  logic          handled_q, handled_d;

  logic [NB-1:0] evt_vld_q, evt_vld_d;
  kind_e         evt_kind_q [NB];
  kind_e         evt_kind_d [NB];

  logic [31:0]   now_q;
  logic [NB-1:0] pins_q;
  logic [NB-1:0] claims_q;
  logic [31:0]   elapsed_q, elapsed_d;
  logic [31:0]   excess_q, excess_d;

  logic                 mod_start;
  logic [3:0]           mod_div;
  mod_st_t              mod_st;
  logic [31:0]          elapsed_now;
  logic [32:0]          diff;
  logic [10:0]          ramp_d;
  logic [3:0]           div_now;
  logic [BTN_IDX_W-1:0] sel;
  logic                 btn_was;
  logic                 btn_is;
  logic                 advance;

  bed_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (ctr_q),
    .divisor_i  (mod_div),
    .status_o   (mod_st)
  );

  // Configuration writes.
  always_comb begin
    rep_mask_d = rep_mask_q;
    poll_d     = poll_q;
    delay_d    = delay_q;
    long_d     = long_q;
    if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_REPEAT_MASK: rep_mask_d = cfg_wdata_i[3:0];
        REG_POLL:        poll_d     = cfg_wdata_i[9:0];
        REG_DELAY:       delay_d    = cfg_wdata_i[13:0];
        REG_LONG:        long_d     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Lowest pending event goes out first.
  always_comb begin
    sel = '0;
    for (int k = NB - 1; k >= 0; k--) begin
      if (evt_vld_q[k]) begin
        sel = BTN_IDX_W'(k);
      end
    end
  end

  assign btn_was     = pressed_q[idx_q];
  assign btn_is      = !pins_q[idx_q];
  assign elapsed_now = now_q - hold_q;
  assign diff        = {1'b0, elapsed_q} - {19'd0, delay_q};
  assign ramp_d      = (excess_q >= {21'd0, RAMP_SPAN}) ? 11'd0 : (RAMP_SPAN - excess_q[10:0]);
  assign div_now     = ramp_div(ramp_d);
  assign mod_div     = div_now;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pressed_d   = pressed_q;
    last_poll_d = last_poll_q;
    hold_d      = hold_q;
    ctr_d       = ctr_q;
    handled_d   = handled_q;
    evt_vld_d   = evt_vld_q;
    evt_kind_d  = evt_kind_q;
    elapsed_d   = elapsed_q;
    excess_d    = excess_q;
    mod_start   = 1'b0;
    advance     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_POLL;
        end
      end
      ST_POLL: begin
        if (now_q > (last_poll_q + {22'd0, poll_q})) begin
          last_poll_d = now_q;
          evt_vld_d   = '0;
          idx_d       = '0;
          state_d     = ST_EVAL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EVAL: begin
        advance = 1'b1;
        if (btn_is != btn_was) begin
          hold_d = now_q;
          ctr_d  = 32'd0;
          if (btn_is) begin
            pressed_d[idx_q]  = 1'b1;
            handled_d         = claims_q[idx_q];
            evt_vld_d[idx_q]  = 1'b1;
            evt_kind_d[idx_q] = KIND_PRESS;
          end else begin
            pressed_d[idx_q] = 1'b0;
            if (!handled_q) begin
              evt_vld_d[idx_q]  = 1'b1;
              evt_kind_d[idx_q] = KIND_CLICK;
            end
            hold_d    = 32'd0;
            handled_d = 1'b0;
          end
        end else if (btn_is) begin
          if (rep_mask_q[idx_q]) begin
            elapsed_d = elapsed_now;
            advance   = 1'b0;
            state_d   = ST_RAMP;
          end else if (!handled_q && !elapsed_now[31] &&
                       (elapsed_now > {16'd0, long_q})) begin
            hold_d            = 32'd0;
            ctr_d             = 32'd0;
            handled_d         = 1'b1;
            evt_vld_d[idx_q]  = 1'b1;
            evt_kind_d[idx_q] = KIND_LONG;
          end
        end
      end
      ST_RAMP: begin
        // A negative elapsed time never passes the delay.
        if (!elapsed_q[31] && !diff[32] && (diff[31:0] != 32'd0)) begin
          excess_d = diff[31:0];
          state_d  = ST_DIV;
        end else begin
          advance = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_now == 4'd0) begin
          evt_vld_d[idx_q]  = 1'b1;
          evt_kind_d[idx_q] = KIND_REPEAT;
          ctr_d             = ctr_q + 32'd1;
          advance           = 1'b1;
        end else begin
          mod_start = 1'b1;
          state_d   = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_st.done) begin
          if (mod_st.zero) begin
            evt_vld_d[idx_q]  = 1'b1;
            evt_kind_d[idx_q] = KIND_REPEAT;
          end
          ctr_d   = ctr_q + 32'd1;
          advance = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (m_axis_tready_i) begin
          evt_vld_d[sel] = 1'b0;
          if (m_axis_tlast_o) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (advance) begin
      if (idx_q == BTN_IDX_W'(NB - 1)) begin
        state_d = (evt_vld_d != '0) ? ST_DRAIN : ST_IDLE;
      end else begin
        idx_d   = idx_q + 1'b1;
        state_d = ST_EVAL;
      end
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_DRAIN);
  assign m_axis_tdata_o  = {{(8 - BTN_IDX_W){1'b0}}, sel};
  assign m_axis_tuser_o  = evt_kind_q[sel];
  assign m_axis_tlast_o  = ((evt_vld_q & (evt_vld_q - 1'b1)) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      rep_mask_q  <= RST_REPEAT_MASK;
      poll_q      <= RST_POLL;
      delay_q     <= RST_DELAY;
      long_q      <= RST_LONG;
      pressed_q   <= '0;
      last_poll_q <= 32'd0;
      hold_q      <= 32'd0;
      ctr_q       <= 32'd0;
      handled_q   <= 1'b0;
      evt_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rep_mask_q  <= rep_mask_d;
      poll_q      <= poll_d;
      delay_q     <= delay_d;
      long_q      <= long_d;
      pressed_q   <= pressed_d;
      last_poll_q <= last_poll_d;
      hold_q      <= hold_d;
      ctr_q       <= ctr_d;
      handled_q   <= handled_d;
      evt_vld_q   <= evt_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_kind_q <= evt_kind_d;
    elapsed_q  <= elapsed_d;
    excess_q   <= excess_d;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      now_q    <= s_axis_tdata_i[31:0];
      pins_q   <= s_axis_tdata_i[35:32];
      claims_q <= s_axis_tdata_i[39:36];
    end
  end

  // Every beat offered on the output carries a pending event.
  a_out_has_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (evt_vld_q != '0))
    else $error("output beat without a pending event");

  // The final beat of a sample returns the block to idle.
  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> (state_q == ST_IDLE))
    else $error("drain did not end after the last beat");

  // The remainder unit reports completion only while the sequencer waits for it.
  a_mod_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_st.done |-> (state_q == ST_MOD))
    else $error("remainder result outside the wait state");

  // A processed sample always records its time as the last poll time.
  a_poll_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POLL && state_d == ST_EVAL) |=> (last_poll_q == now_q))
    else $error("poll time not recorded");

endmodule
